@@ hw/rtl/felm_pkg.sv @@
// Shared types and constants for the FAT entry locate, decode and merge block.
package felm_pkg;

  // Width of the offset outputs and of the wide configuration registers.
  localparam int unsigned OUT_BITS    = 48;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_INDEX_W = 3;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Entry masks and end-of-chain limits.
  localparam logic [31:0] FAT12_MASK    = 32'h0000_0FFF;
  localparam logic [31:0] FAT12_HI_NIB  = 32'h0000_F000;
  localparam logic [31:0] FAT12_LO_NIB  = 32'h0000_000F;
  localparam logic [31:0] FAT12_SH_MASK = 32'h0000_FFF0;
  localparam logic [31:0] FAT16_MASK    = 32'h0000_FFFF;
  localparam logic [31:0] FAT32_MASK    = 32'h0FFF_FFFF;
  localparam logic [31:0] FAT32_HI_NIB  = 32'hF000_0000;
  localparam logic [31:0] FAT12_EOC     = 32'h0000_0FF8;
  localparam logic [31:0] FAT16_EOC     = 32'h0000_FFF8;
  localparam logic [31:0] FAT32_EOC     = 32'h0FFF_FFF8;

  // Access sizes in bytes.
  localparam logic [2:0] ACC_NONE  = 3'd0;
  localparam logic [2:0] ACC_16BIT = 3'd2;
  localparam logic [2:0] ACC_32BIT = 3'd4;

  // Configured table type.
  typedef enum logic [1:0] {
    FT_NONE = 2'd0,
    FT_12   = 2'd1,
    FT_16   = 2'd2,
    FT_32   = 2'd3
  } fat_type_e;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FAT_TYPE     = 3'd0,
    REG_RESERVED     = 3'd1,
    REG_SECTOR_BYTES = 3'd2,
    REG_FAT_SECTORS  = 3'd3,
    REG_CLUS_SECTORS = 3'd4,
    REG_DATA_START   = 3'd5,
    REG_ROOT_START   = 3'd6
  } cfg_index_e;

  // Current configuration, as seen by the front and the back.
  typedef struct packed {
    fat_type_e      fat_type;
    logic [15:0]    reserved;
    logic [12:0]    sector_bytes;
    logic [31:0]    fat_sectors;
    logic [7:0]     cluster_sectors;
    logic [47:0]    data_start;
    logic [47:0]    root_start;
  } cfg_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [27:0] ent;
    logic        eoc;
    logic [31:0] wr;
    logic [2:0]  acc;
    logic        terr;
    logic [29:0] eoff;
    logic        gt1;
    logic [39:0] p_copy;
    logic [35:0] p_clus;
    logic [28:0] p_res;
  } item_t;

endpackage

@@ hw/rtl/felm_cfg.sv @@
// Configuration register file with reset defaults.
module felm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [felm_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [felm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output felm_pkg::cfg_t                      cfg_o
);

  felm_pkg::cfg_t cfg_d, cfg_q;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (felm_pkg::cfg_index_e'(cfg_index_i))
        felm_pkg::REG_FAT_TYPE:     cfg_d.fat_type = felm_pkg::fat_type_e'(cfg_data_i[1:0]);
        felm_pkg::REG_RESERVED:     cfg_d.reserved = cfg_data_i[15:0];
        felm_pkg::REG_SECTOR_BYTES: cfg_d.sector_bytes = cfg_data_i[12:0];
        felm_pkg::REG_FAT_SECTORS:  cfg_d.fat_sectors = cfg_data_i[31:0];
        felm_pkg::REG_CLUS_SECTORS: cfg_d.cluster_sectors = cfg_data_i[7:0];
        felm_pkg::REG_DATA_START:   cfg_d.data_start = cfg_data_i[47:0];
        felm_pkg::REG_ROOT_START:   cfg_d.root_start = cfg_data_i[47:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fat_type        <= felm_pkg::FT_NONE;
      cfg_q.reserved        <= 16'd1;
      cfg_q.sector_bytes    <= 13'd512;
      cfg_q.fat_sectors     <= 32'd0;
      cfg_q.cluster_sectors <= 8'd1;
      cfg_q.data_start      <= 48'd0;
      cfg_q.root_start      <= 48'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/felm_front.sv @@
// Front stage: accepts items, decodes and merges the entry, starts the offset products.
module felm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  felm_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [27:0]        cluster_number_i,
  input  logic [7:0]         fat_copy_i,
  input  logic [31:0]        raw_word_i,
  input  logic [31:0]        new_value_i,
  output logic               push_o,
  output felm_pkg::item_t    item_o,
  input  logic               q_full_i
);

  logic            valid_d, valid_q;
  logic            accept;
  felm_pkg::item_t item_d, item_q;
  logic [31:0]     raw16;
  logic            odd;
  logic [27:0]     clus_m2;
  logic [27:0]     ent;

  assign in_stall_o = valid_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = valid_q & ~q_full_i;

  assign raw16   = raw_word_i & felm_pkg::FAT16_MASK;
  assign odd     = cluster_number_i[0];
  assign clus_m2 = cluster_number_i - 28'd2;

  // Classify by table type: entry offset, decode, merge and access size.
  always_comb begin
    ent          = 28'd0;
    item_d       = '0;
    item_d.terr  = 1'b0;
    unique case (cfg_i.fat_type)
      felm_pkg::FT_12: begin
        item_d.eoff = 30'(cluster_number_i) + 30'(cluster_number_i[27:1]);
        item_d.acc  = felm_pkg::ACC_16BIT;
        ent         = odd ? 28'(raw16 >> 4) : 28'(raw16 & felm_pkg::FAT12_MASK);
        item_d.eoc  = ent >= 28'(felm_pkg::FAT12_EOC);
        if (odd) begin
          item_d.wr = ((new_value_i << 4) & felm_pkg::FAT12_SH_MASK)
                    | (raw16 & felm_pkg::FAT12_LO_NIB);
        end else begin
          item_d.wr = (new_value_i & felm_pkg::FAT12_MASK)
                    | (raw16 & felm_pkg::FAT12_HI_NIB);
        end
      end
      felm_pkg::FT_16: begin
        item_d.eoff = {1'b0, cluster_number_i, 1'b0};
        item_d.acc  = felm_pkg::ACC_16BIT;
        ent         = 28'(raw16);
        item_d.eoc  = ent >= 28'(felm_pkg::FAT16_EOC);
        item_d.wr   = new_value_i & felm_pkg::FAT16_MASK;
      end
      felm_pkg::FT_32: begin
        item_d.eoff = {cluster_number_i, 2'b00};
        item_d.acc  = felm_pkg::ACC_32BIT;
        ent         = 28'(raw_word_i & felm_pkg::FAT32_MASK);
        item_d.eoc  = ent >= 28'(felm_pkg::FAT32_EOC);
        item_d.wr   = (new_value_i & felm_pkg::FAT32_MASK)
                    | (raw_word_i & felm_pkg::FAT32_HI_NIB);
      end
      default: begin
        item_d.acc  = felm_pkg::ACC_NONE;
        item_d.wr   = ~new_value_i;
        item_d.terr = 1'b1;
      end
    endcase
    item_d.ent    = ent;
    // First halves of the offset products.
    item_d.gt1    = |cluster_number_i[27:1];
    item_d.p_copy = fat_copy_i * cfg_i.fat_sectors;
    item_d.p_clus = clus_m2 * cfg_i.cluster_sectors;
    item_d.p_res  = cfg_i.reserved * cfg_i.sector_bytes;
  end

  // The stage holds its item until the queue has room.
  assign valid_d = accept | (valid_q & q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

@@ hw/rtl/felm_queue.sv @@
// Short queue of classified items between the front and the back.
module felm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  felm_pkg::item_t    item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output felm_pkg::item_t    item_o
);

  localparam int unsigned PTR_W = (felm_pkg::QUEUE_DEPTH > 1) ? $clog2(felm_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(felm_pkg::QUEUE_DEPTH + 1);

  felm_pkg::item_t    mem_q [felm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_d, wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_d, rd_ptr_q;
  logic [CNT_W-1:0]   count_d, count_q;

  assign full_o  = count_q == CNT_W'(felm_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(felm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(felm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hw/rtl/felm_back.sv @@
// Back stages: finish the offset products, form the offsets and hold the result.
module felm_back #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  felm_pkg::cfg_t     cfg_i,
  input  logic               q_valid_i,
  input  felm_pkg::item_t    item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [47:0]        fat_byte_offset_o,
  output logic [2:0]         access_bytes_o,
  output logic [27:0]        entry_value_o,
  output logic               end_of_chain_o,
  output logic [31:0]        write_word_o,
  output logic [47:0]        data_byte_offset_o,
  output logic               type_error_o
);

  logic                   b_valid_d, b_valid_q;
  logic                   c_valid_d, c_valid_q;
  logic                   b_ready, c_ready, c_load;
  felm_pkg::item_t        b_item_q;
  logic [52:0]            b_hi_d, b_hi_q;
  logic [48:0]            b_dp_d, b_dp_q;
  logic [OFFSET_BITS-1:0] fat_sum, data_sum;

  // Elastic handshake through the two back stages.
  assign c_ready = ~c_valid_q | ~out_stall_i;
  assign b_ready = ~b_valid_q | c_ready;
  assign pop_o   = q_valid_i & b_ready;
  assign c_load  = b_valid_q & c_ready;

  assign b_valid_d = pop_o | (b_valid_q & ~c_ready);
  assign c_valid_d = c_load | (c_valid_q & out_stall_i);

  // Second halves of the products: scale by the sector size.
  assign b_hi_d = item_i.p_copy * cfg_i.sector_bytes;
  assign b_dp_d = item_i.p_clus * cfg_i.sector_bytes;

  // Offset sums wrap at the offset width.
  assign fat_sum  = OFFSET_BITS'(b_item_q.p_res) + OFFSET_BITS'(b_hi_q)
                  + OFFSET_BITS'(b_item_q.eoff);
  assign data_sum = b_item_q.gt1 ? (OFFSET_BITS'(cfg_i.data_start) + OFFSET_BITS'(b_dp_q))
                                 : OFFSET_BITS'(cfg_i.root_start);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      c_valid_q <= c_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_item_q <= item_i;
      b_hi_q   <= b_hi_d;
      b_dp_q   <= b_dp_d;
    end
  end

  // Output register holds the result until it is taken.
  always_ff @(posedge clk_i) begin
    if (c_load) begin
      fat_byte_offset_o  <= b_item_q.terr ? 48'd0 : 48'(fat_sum);
      access_bytes_o     <= b_item_q.acc;
      entry_value_o      <= b_item_q.ent;
      end_of_chain_o     <= b_item_q.eoc;
      write_word_o       <= b_item_q.wr;
      data_byte_offset_o <= 48'(data_sum);
      type_error_o       <= b_item_q.terr;
    end
  end

  assign out_valid_o = c_valid_q;

endmodule

@@ hw/rtl/fat_entry_locate_decode_merge_core.sv @@
// Top level of the FAT entry locate, decode and merge block.
// Path: front register, queue, back register, then the output register. Throughput:
// one item per cycle while out_stall_i is low; the two-entry queue between front and
// back keeps the front accepting while output waits, until five items are held inside.
// Reset: configuration returns to its defaults, and the front, queue and back empty.
module fat_entry_locate_decode_merge_core #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [felm_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [felm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [27:0]                        cluster_number_i,
  input  logic [7:0]                         fat_copy_i,
  input  logic [31:0]                        raw_word_i,
  input  logic [31:0]                        new_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [47:0]                        fat_byte_offset_o,
  output logic [2:0]                         access_bytes_o,
  output logic [27:0]                        entry_value_o,
  output logic                               end_of_chain_o,
  output logic [31:0]                        write_word_o,
  output logic [47:0]                        data_byte_offset_o,
  output logic                               type_error_o
);

  felm_pkg::cfg_t  cfg;
  felm_pkg::item_t front_item, queue_item;
  logic            push, q_full, pop, q_valid;

  // Configuration registers.
  felm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Front: accept and classify.
  felm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cluster_number_i (cluster_number_i),
    .fat_copy_i       (fat_copy_i),
    .raw_word_i       (raw_word_i),
    .new_value_i      (new_value_i),
    .push_o           (push),
    .item_o           (front_item),
    .q_full_i         (q_full)
  );

  // Queue between front and back.
  felm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  // Back: offsets and result register.
  felm_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .q_valid_i          (q_valid),
    .item_i             (queue_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .fat_byte_offset_o  (fat_byte_offset_o),
    .access_bytes_o     (access_bytes_o),
    .entry_value_o      (entry_value_o),
    .end_of_chain_o     (end_of_chain_o),
    .write_word_o       (write_word_o),
    .data_byte_offset_o (data_byte_offset_o),
    .type_error_o       (type_error_o)
  );

endmodule

@@ bench/felm_result_checker.sv @@
// Result checker for the FAT entry locate, decode and merge block.
`timescale 1ns / 1ps

module felm_result_checker #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [felm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [felm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [27:0]                      cluster_number_i,
  input  logic [7:0]                       fat_copy_i,
  input  logic [31:0]                      raw_word_i,
  input  logic [31:0]                      new_value_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [47:0]                      fat_byte_offset_i,
  input  logic [2:0]                       access_bytes_i,
  input  logic [27:0]                      entry_value_i,
  input  logic                             end_of_chain_i,
  input  logic [31:0]                      write_word_i,
  input  logic [47:0]                      data_byte_offset_i,
  input  logic                             type_error_i,
  output int                               pending_o,
  output int                               errors_o
);

  // Offsets wrap at the configured width.
  localparam logic [63:0] OFS_MASK =
      (OFFSET_BITS >= 64) ? {64{1'b1}} : ((64'd1 << OFFSET_BITS) - 64'd1);

  // Entry field masks and end-of-chain limits per table type.
  localparam logic [31:0] ENT12_MASK   = 32'h0000_0FFF;
  localparam logic [31:0] KEEP12_HIGH  = 32'h0000_F000;
  localparam logic [31:0] KEEP12_LOW   = 32'h0000_000F;
  localparam logic [31:0] SHIFT12_MASK = 32'h0000_FFF0;
  localparam logic [31:0] ENT16_MASK   = 32'h0000_FFFF;
  localparam logic [31:0] ENT32_MASK   = 32'h0FFF_FFFF;
  localparam logic [31:0] KEEP32_HIGH  = 32'hF000_0000;
  localparam logic [27:0] LAST12       = 28'h000_0FF8;
  localparam logic [27:0] LAST16       = 28'h000_FFF8;
  localparam logic [27:0] LAST32       = 28'hFFF_FFF8;

  // Access sizes in bytes.
  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  typedef struct packed {
    logic [47:0] fat_byte_offset;
    logic [2:0]  access_bytes;
    logic [27:0] entry_value;
    logic        end_of_chain;
    logic [31:0] write_word;
    logic [47:0] data_byte_offset;
    logic        type_error;
  } entry_access_t;

  felm_pkg::cfg_t cfg_q;
  entry_access_t  expected_access[$];
  entry_access_t  want;
  int             mismatch_count;
  int             pending_count;

  assign errors_o  = mismatch_count;
  assign pending_o = pending_count;

  // Locate, decode and merge one table entry under the given configuration.
  function automatic entry_access_t locate_and_merge(felm_pkg::cfg_t cfg, logic [27:0] clus,
                                                     logic [7:0] copy, logic [31:0] raw,
                                                     logic [31:0] nv);
    entry_access_t r;
    logic [63:0]   base;
    logic [63:0]   eoff;
    logic [63:0]   data_ofs;
    logic [31:0]   raw16;
    logic          odd;
    r     = '0;
    eoff  = '0;
    raw16 = raw & ENT16_MASK;
    odd   = clus[0];
    base  = 64'(cfg.reserved) * 64'(cfg.sector_bytes)
          + 64'(copy) * 64'(cfg.fat_sectors) * 64'(cfg.sector_bytes);

    case (cfg.fat_type)
      felm_pkg::FT_12: begin
        eoff             = 64'(clus) + 64'(clus >> 1);
        r.access_bytes   = SIZE_HALF;
        r.entry_value    = odd ? 28'(raw16 >> 4) : 28'(raw16 & ENT12_MASK);
        r.end_of_chain   = (r.entry_value >= LAST12);
        // The neighboring entry shares one nibble of the 16-bit word.
        if (odd) begin
          r.write_word = ((nv << 4) & SHIFT12_MASK) | (raw16 & KEEP12_LOW);
        end else begin
          r.write_word = (nv & ENT12_MASK) | (raw16 & KEEP12_HIGH);
        end
      end
      felm_pkg::FT_16: begin
        eoff           = 64'(clus) * 64'd2;
        r.access_bytes = SIZE_HALF;
        r.entry_value  = 28'(raw16);
        r.end_of_chain = (r.entry_value >= LAST16);
        r.write_word   = nv & ENT16_MASK;
      end
      felm_pkg::FT_32: begin
        eoff           = 64'(clus) * 64'd4;
        r.access_bytes = SIZE_WORD;
        r.entry_value  = 28'(raw & ENT32_MASK);
        r.end_of_chain = (r.entry_value >= LAST32);
        // The top nibble is reserved and written back unchanged.
        r.write_word   = (nv & ENT32_MASK) | (raw & KEEP32_HIGH);
      end
      default: begin
        r.access_bytes = SIZE_NONE;
        r.write_word   = ~nv;
        r.type_error   = 1'b1;
      end
    endcase

    if (cfg.fat_type != felm_pkg::FT_NONE) begin
      r.fat_byte_offset = 48'((base + eoff) & OFS_MASK);
    end

    // Clusters 0 and 1 point at the root directory.
    if (clus > 28'd1) begin
      data_ofs = (64'(cfg.data_start) + (64'(clus) - 64'd2) * 64'(cfg.cluster_sectors)
                  * 64'(cfg.sector_bytes)) & OFS_MASK;
    end else begin
      data_ofs = 64'(cfg.root_start) & OFS_MASK;
    end
    r.data_byte_offset = 48'(data_ofs);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Track register writes, predict each input transaction, compare each result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fat_type        <= felm_pkg::FT_NONE;
      cfg_q.reserved        <= 16'd1;
      cfg_q.sector_bytes    <= 13'd512;
      cfg_q.fat_sectors     <= '0;
      cfg_q.cluster_sectors <= 8'd1;
      cfg_q.data_start      <= '0;
      cfg_q.root_start      <= '0;
      expected_access.delete();
      mismatch_count = 0;
      pending_count  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          felm_pkg::REG_FAT_TYPE:
            cfg_q.fat_type        <= felm_pkg::fat_type_e'(cfg_data_i[1:0]);
          felm_pkg::REG_RESERVED:     cfg_q.reserved        <= cfg_data_i[15:0];
          felm_pkg::REG_SECTOR_BYTES: cfg_q.sector_bytes    <= cfg_data_i[12:0];
          felm_pkg::REG_FAT_SECTORS:  cfg_q.fat_sectors     <= cfg_data_i[31:0];
          felm_pkg::REG_CLUS_SECTORS: cfg_q.cluster_sectors <= cfg_data_i[7:0];
          felm_pkg::REG_DATA_START:   cfg_q.data_start      <= cfg_data_i[47:0];
          felm_pkg::REG_ROOT_START:   cfg_q.root_start      <= cfg_data_i[47:0];
          default: ;
        endcase
      end

      // Results are matched before the new input is queued.
      if (out_valid_i && !out_stall_i) begin
        if (expected_access.size() == 0) begin
          $error("result transaction with no input outstanding");
          mismatch_count++;
        end else begin
          want = expected_access.pop_front();
          check_field("fat_byte_offset", want.fat_byte_offset, fat_byte_offset_i);
          check_field("access_bytes", want.access_bytes, access_bytes_i);
          check_field("entry_value", want.entry_value, entry_value_i);
          check_field("end_of_chain", want.end_of_chain, end_of_chain_i);
          check_field("write_word", want.write_word, write_word_i);
          check_field("data_byte_offset", want.data_byte_offset, data_byte_offset_i);
          check_field("type_error", want.type_error, type_error_i);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        expected_access.push_back(locate_and_merge(cfg_q, cluster_number_i, fat_copy_i,
                                                   raw_word_i, new_value_i));
      end
      pending_count = expected_access.size();
    end
  end

endmodule

@@ bench/tb_fat_entry_locate_decode_merge_core.sv @@
// Stimulus and verdict for the FAT entry locate, decode and merge block.
`timescale 1ns / 1ps

module tb_fat_entry_locate_decode_merge_core;

  localparam int unsigned OFS_BITS        = 48;
  localparam int unsigned RAND_PHASES     = 12;
  localparam int unsigned ITEMS_PER_PHASE = 162;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  // Register index with no register behind it.
  localparam logic [felm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we;
  logic [felm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [felm_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic [27:0]                      cluster_number;
  logic [7:0]                       fat_copy;
  logic [31:0]                      raw_word;
  logic [31:0]                      new_value;
  logic                             out_valid;
  logic                             out_stall;
  logic [47:0]                      fat_byte_offset;
  logic [2:0]                       access_bytes;
  logic [27:0]                      entry_value;
  logic                             end_of_chain;
  logic [31:0]                      write_word;
  logic [47:0]                      data_byte_offset;
  logic                             type_error;
  int                               pending;
  int                               mismatches;
  logic                             in_taken_q;
  int unsigned                      stuck_cycles;

  fat_entry_locate_decode_merge_core #(
    .OFFSET_BITS(OFS_BITS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .cluster_number_i   (cluster_number),
    .fat_copy_i         (fat_copy),
    .raw_word_i         (raw_word),
    .new_value_i        (new_value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .fat_byte_offset_o  (fat_byte_offset),
    .access_bytes_o     (access_bytes),
    .entry_value_o      (entry_value),
    .end_of_chain_o     (end_of_chain),
    .write_word_o       (write_word),
    .data_byte_offset_o (data_byte_offset),
    .type_error_o       (type_error)
  );

  felm_result_checker #(
    .OFFSET_BITS(OFS_BITS)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .cluster_number_i   (cluster_number),
    .fat_copy_i         (fat_copy),
    .raw_word_i         (raw_word),
    .new_value_i        (new_value),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .fat_byte_offset_i  (fat_byte_offset),
    .access_bytes_i     (access_bytes),
    .entry_value_i      (entry_value),
    .end_of_chain_i     (end_of_chain),
    .write_word_i       (write_word),
    .data_byte_offset_i (data_byte_offset),
    .type_error_i       (type_error),
    .pending_o          (pending),
    .errors_o           (mismatches)
  );

  // Free-running clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Remember whether the last rising edge took an input transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken_q <= 1'b0;
    end else begin
      in_taken_q <= in_valid && !in_stall;
    end
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("[fat_entry_locate_decode_merge_core] ERROR");
        $finish;
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Register value of the given width, biased to the extremes, with junk above it.
  function automatic logic [47:0] rand_reg(int unsigned w);
    logic [47:0] ones;
    logic [47:0] v;
    ones = (48'd1 << w) - 48'd1;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = ones;
      2:       v = 48'($urandom_range(1, 16)) & ones;
      default: v = rand48() & ones;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      v |= rand48() & ~ones;
    end
    return v;
  endfunction

  // Result side: stall in bursts, with some long stretches of free flow.
  initial begin
    int unsigned run_len;
    int unsigned hold_len;
    out_stall = 1'b0;
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        run_len = $urandom_range(60, 200);
      end else begin
        run_len = $urandom_range(1, 12);
      end
      repeat (run_len) @(negedge clk_i);
      if ($urandom_range(0, 99) < 85) begin
        hold_len = $urandom_range(1, 3);
      end else begin
        hold_len = $urandom_range(8, 40);
      end
      out_stall <= 1'b1;
      repeat (hold_len) @(negedge clk_i);
      out_stall <= 1'b0;
    end
  end

  // Offer one input transaction and wait until the block takes it.
  task automatic send_entry(input logic [27:0] clus, input logic [7:0] copy,
                            input logic [31:0] raw, input logic [31:0] nv,
                            input bit with_gaps);
    int unsigned gap;
    gap = with_gaps ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid       <= 1'b1;
    cluster_number <= clus;
    fat_copy       <= copy;
    raw_word       <= raw;
    new_value      <= nv;
    do @(negedge clk_i); while (!in_taken_q);
  endtask

  // Wait until every result has come out and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [felm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
  endtask

  // Rewrite every register while the block is idle; the unused index gets junk.
  task automatic load_config(input logic [47:0] ftype, input logic [47:0] resv,
                             input logic [47:0] sec_bytes, input logic [47:0] fat_secs,
                             input logic [47:0] clus_secs, input logic [47:0] data_start,
                             input logic [47:0] root_start);
    settle();
    write_reg(felm_pkg::REG_FAT_TYPE, ftype);
    write_reg(felm_pkg::REG_RESERVED, resv);
    write_reg(felm_pkg::REG_SECTOR_BYTES, sec_bytes);
    write_reg(felm_pkg::REG_FAT_SECTORS, fat_secs);
    write_reg(felm_pkg::REG_CLUS_SECTORS, clus_secs);
    write_reg(felm_pkg::REG_DATA_START, data_start);
    write_reg(felm_pkg::REG_ROOT_START, root_start);
    write_reg(REG_UNUSED, rand48());
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk_i);
  endtask

  initial begin
    logic [27:0] clus;
    logic [7:0]  copy;
    logic [31:0] raw;
    logic [31:0] nv;
    logic [47:0] sec_bytes;
    int unsigned k;
    bit          calm;

    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = felm_pkg::REG_FAT_TYPE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    cluster_number = '0;
    fat_copy       = '0;
    raw_word       = '0;
    new_value      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: no table type, so only the data offset is live.
    send_entry(28'd0, 8'd0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_entry(28'd1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_entry(28'd2, 8'd0, 32'h1234_5678, 32'hA5A5_A5A5, 1'b1);
    send_entry(28'hFFF_FFFF, 8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b1);

    // FAT12: odd and even clusters on both sides of the end-of-chain limit.
    load_config(48'(felm_pkg::FT_12), 48'd32, 48'd512, 48'd9, 48'd4, 48'h4000, 48'h2600);
    send_entry(28'd2, 8'd0, 32'hFFFF_0FF8, 32'h0000_0ABC, 1'b1);
    send_entry(28'd3, 8'd1, 32'h0000_FF7F, 32'hFFFF_FFFF, 1'b1);
    send_entry(28'd3, 8'd1, 32'hFFFF_FF8F, 32'h0000_0000, 1'b1);
    send_entry(28'd4, 8'd0, 32'hFFFF_0FF7, 32'hFFFF_FFFF, 1'b1);
    send_entry(28'hFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1);

    // FAT16: the limit and the root clusters.
    load_config(48'(felm_pkg::FT_16), 48'd4, 48'd512, 48'd256, 48'd8, 48'h4_0000,
                48'h2_0000);
    send_entry(28'd0, 8'd0, 32'hABCD_FFF7, 32'hFFFF_FFFF, 1'b1);
    send_entry(28'd1, 8'hFF, 32'hFFFF_FFF8, 32'h0000_0000, 1'b1);
    send_entry(28'd5, 8'd2, 32'h0000_FFFF, 32'h8765_4321, 1'b1);

    // FAT32: the 28-bit mask, the reserved top nibble and the limit.
    load_config(48'(felm_pkg::FT_32), 48'd32, 48'd4096, 48'd1000, 48'd128, 48'h10_0000,
                48'd0);
    send_entry(28'd2, 8'd0, 32'hFFFF_FFF7, 32'hFFFF_FFFF, 1'b1);
    send_entry(28'd3, 8'd1, 32'h0FFF_FFF8, 32'h0000_0000, 1'b1);
    send_entry(28'hFFF_FFFF, 8'hFF, 32'hF000_0000, 32'hFFFF_FFFF, 1'b1);
    send_entry(28'd7, 8'd0, 32'h0FFF_FFFF, 32'h5A5A_5A5A, 1'b1);

    // All registers at their maximum: offsets wrap.
    load_config('1, '1, '1, '1, '1, '1, '1);
    send_entry(28'hFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_entry(28'd2, 8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_entry(28'd1, 8'd0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);

    // All sizes zero: odd values are used as written.
    load_config(48'(felm_pkg::FT_12), '0, '0, '0, '0, '0, '0);
    send_entry(28'hFFF_FFFF, 8'hFF, 32'h0000_FFFF, 32'h0000_FFFF, 1'b1);
    send_entry(28'd3, 8'd0, 32'h0000_1234, 32'h0000_0000, 1'b1);

    // Random phases, each under a fresh random configuration.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        sec_bytes = rand_reg(13);
      end else begin
        sec_bytes = 48'd512 << $urandom_range(0, 3);
      end
      load_config(rand_reg(2), rand_reg(16), sec_bytes, rand_reg(32), rand_reg(8),
                  rand_reg(48), rand_reg(48));
      calm = (ph % 4 == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(0, 9))
          0, 1:    clus = 28'($urandom_range(0, 3));
          2:       clus = 28'hFFF_FFFF - 28'($urandom_range(0, 3));
          default: clus = 28'($urandom());
        endcase
        if ($urandom_range(0, 3) == 0) begin
          copy = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'hFF;
        end else begin
          copy = 8'($urandom());
        end
        raw = $urandom();
        // Put the entry close to one of the end-of-chain limits now and then.
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, 3);
          case ($urandom_range(0, 3))
            0:       raw[11:0] = 12'hFF6 + 12'(k);
            1:       raw[15:4] = 12'hFF6 + 12'(k);
            2:       raw[15:0] = 16'hFFF6 + 16'(k);
            default: raw[27:0] = 28'hFFF_FFF6 + 28'(k);
          endcase
        end
        case ($urandom_range(0, 7))
          0:       nv = 32'h0000_0000;
          1:       nv = 32'hFFFF_FFFF;
          default: nv = $urandom();
        endcase
        send_entry(clus, copy, raw, nv, !calm);
      end
    end

    // Let the last results drain, then give the verdict.
    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("[fat_entry_locate_decode_merge_core] OK");
    end else begin
      $display("[fat_entry_locate_decode_merge_core] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/felm_pkg.sv
hw/rtl/felm_cfg.sv
hw/rtl/felm_front.sv
hw/rtl/felm_queue.sv
hw/rtl/felm_back.sv
hw/rtl/fat_entry_locate_decode_merge_core.sv
bench/felm_result_checker.sv
bench/tb_fat_entry_locate_decode_merge_core.sv
